[hdl/ffic_pkg.sv]
// Shared types, constants and the byte-wide CRC-32 update for the file check unit.
// No dependencies; used by ffic_check and framed_file_integrity_check_unit.
`default_nettype none

package ffic_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [31:0] MAGIC_RESET   = 32'h42474253;
  localparam logic [31:0] MIN_VER_RESET = 32'd2;
  localparam logic [31:0] MAX_VER_RESET = 32'd4;

  // Byte offsets inside the file header.
  localparam logic [3:0] VER_START = 4'd4;
  localparam logic [3:0] HDR_BYTES = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_MIN_VER = 2'd1;
  localparam logic [1:0] CFG_MAX_VER = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_HDR  = 2'd1,
    ST_CRC_ERR  = 2'd2,
    ST_BAD_VER  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [31:0] min_version;
    logic [31:0] max_version;
  } cfg_t;

  typedef struct packed {
    logic [31:0] file_version;
    logic [31:0] computed_crc;
    status_t     status;
  } result_t;

  // Reflected CRC-32 update over one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
    end
    return x;
  endfunction

endpackage

`default_nettype wire

[hdl/framed_file_integrity_check_unit.sv]
// Framed file integrity check: magic word, minimum length, CRC-32 trailer and version range.
// A request's byte is registered, then checked; the verdict on the last byte is registered in
// the result register. Throughput: 1 byte per cycle, set by the one-byte CRC update stage,
// except that a last byte waits while an earlier result is still held downstream.
// Reset (rst_n low, synchronous): registers return to their defaults, file state clears,
// both stages empty.
`default_nettype none

module framed_file_integrity_check_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // is_last
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [1:0] status, [33:2] computed_crc,
                                       // [65:34] file_version, [71:66] zero
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  // Configuration registers.
  ffic_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_word  <= ffic_pkg::MAGIC_RESET;
      cfg_r.min_version <= ffic_pkg::MIN_VER_RESET;
      cfg_r.max_version <= ffic_pkg::MAX_VER_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        ffic_pkg::CFG_MAGIC:   cfg_r.magic_word  <= cfg_wdata;
        ffic_pkg::CFG_MIN_VER: cfg_r.min_version <= cfg_wdata;
        ffic_pkg::CFG_MAX_VER: cfg_r.max_version <= cfg_wdata;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Input register: holds one request until the check stage takes it.
  logic            in_v_r;
  ffic_pkg::item_t in_item_r;
  logic            out_free;
  logic            fire;
  logic            out_load;
  logic            out_v_r, out_v_nxt;

  // Output slot can take a result if empty or being drained this cycle.
  assign out_free  = !out_v_r || out_tready;
  // Mid-file bytes always advance; the last byte waits for room in the output slot.
  assign fire      = in_v_r && (!in_item_r.is_last || out_free);
  assign out_load  = fire && in_item_r.is_last;
  assign in_tready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.data_byte <= in_tdata;
      in_item_r.is_last   <= in_tlast;
    end
  end

  // Check stage: running file state and the end-of-file verdict.
  ffic_pkg::result_t res;

  ffic_check u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Result register: hold until the downstream side takes it.
  ffic_pkg::result_t out_res_r;

  assign out_v_nxt = out_load || (out_v_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b000000, out_res_r};

`ifndef ASSERT_OFF
  // A stalled result is never overwritten by a new verdict.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |-> !out_load)
    else $error("result overwritten while stalled");

  // A loaded verdict shows as valid in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_v_r)
    else $error("loaded result not presented");

  // A held request keeps its byte until the check stage takes it.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !fire) |=> (in_v_r && $stable(in_item_r)))
    else $error("pending input lost");

  // An empty input register always takes a new request.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> in_tready)
    else $error("input stalled while empty");
`endif

endmodule

`default_nettype wire

[hdl/ffic_check.sv]
// Per-file check state: magic compare, version capture, CRC over delayed bytes.
// Depends on ffic_pkg.
`default_nettype none

module ffic_check (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire ffic_pkg::item_t  item,
  input  wire ffic_pkg::cfg_t   cfg,
  output ffic_pkg::result_t     res
);

  logic [31:0] crc_r, crc_nxt;
  logic [7:0]  tail_r [4];
  logic [7:0]  tail_nxt [4];
  logic [3:0]  cnt_r, cnt_nxt;
  logic        magic_ok_r, magic_ok_nxt;
  logic [31:0] ver_r, ver_nxt;
  logic [31:0] stored;

  always_comb begin
    magic_ok_nxt = magic_ok_r;
    ver_nxt      = ver_r;
    if (cnt_r < ffic_pkg::VER_START) begin
      magic_ok_nxt = magic_ok_r &&
                     (item.data_byte == cfg.magic_word[{cnt_r[1:0], 3'b000} +: 8]);
    end else if (cnt_r < ffic_pkg::HDR_BYTES) begin
      ver_nxt[{cnt_r[1:0], 3'b000} +: 8] = item.data_byte;
    end

    // Oldest byte leaves the delay line and, once four bytes are in it, enters the CRC.
    crc_nxt = (cnt_r >= ffic_pkg::VER_START) ? ffic_pkg::crc_byte(crc_r, tail_r[0]) : crc_r;
    tail_nxt[0] = tail_r[1];
    tail_nxt[1] = tail_r[2];
    tail_nxt[2] = tail_r[3];
    tail_nxt[3] = item.data_byte;

    cnt_nxt = cnt_r[3] ? cnt_r : cnt_r + 4'd1;

    stored = {tail_nxt[3], tail_nxt[2], tail_nxt[1], tail_nxt[0]};
    res.computed_crc = crc_nxt ^ ffic_pkg::CRC_INIT;
    res.file_version = ver_nxt;
    if (!cnt_nxt[3] || !magic_ok_nxt) begin
      res.status = ffic_pkg::ST_BAD_HDR;
    end else if (stored != res.computed_crc) begin
      res.status = ffic_pkg::ST_CRC_ERR;
    end else if (ver_nxt < cfg.min_version || ver_nxt > cfg.max_version) begin
      res.status = ffic_pkg::ST_BAD_VER;
    end else begin
      res.status = ffic_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= ffic_pkg::CRC_INIT;
      cnt_r      <= '0;
      magic_ok_r <= 1'b1;
      ver_r      <= '0;
    end else if (step) begin
      if (item.is_last) begin
        crc_r      <= ffic_pkg::CRC_INIT;
        cnt_r      <= '0;
        magic_ok_r <= 1'b1;
        ver_r      <= '0;
      end else begin
        crc_r      <= crc_nxt;
        cnt_r      <= cnt_nxt;
        magic_ok_r <= magic_ok_nxt;
        ver_r      <= ver_nxt;
      end
    end
  end

  // Tail bytes are only read once the counter shows they were written.
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 4; i++) begin
        tail_r[i] <= tail_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire
